// ===== rtl/rwcp_pkg.sv =====
`timescale 1ns / 1ps

package rwcp_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_FMT    = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // End report status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_PCM  = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  localparam logic [31:0] TAG_FMT      = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA     = 32'h6461_7461;
  localparam logic [15:0] FMT_PCM      = 16'h0001;
  localparam logic [31:0] DEFAULT_RATE = 32'd22050;
  localparam logic [15:0] DEPTH8       = 16'd8;
  localparam logic [15:0] DEPTH16      = 16'd16;
  localparam logic [15:0] MONO         = 16'd1;

  localparam int RWCP_OUT_DEPTH = 4;

  typedef enum logic [5:0] {
    PH_FILEHDR  = 6'b000001,
    PH_CHUNKHDR = 6'b000010,
    PH_FMT      = 6'b000100,
    PH_DATA     = 6'b001000,
    PH_SKIP     = 6'b010000,
    PH_IDLE     = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  format_code;
    logic [31:0] sample_rate;
    logic [31:0] data_size;
    logic [7:0]  sample_byte;
    logic [1:0]  status;
    logic        last;
  } result_t;

  // Up to two results produced by one item; v1 implies v0.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

  // Replace one byte of a little-endian 32-bit field.
  function automatic logic [31:0] put_byte(input logic [31:0] field,
                                           input logic [1:0] pos,
                                           input logic [7:0] b);
    logic [31:0] res;
    res = field;
    res[pos*8 +: 8] = b;
    return res;
  endfunction

endpackage

// ===== rtl/riff_wave_chunk_parser.sv =====
`timescale 1ns / 1ps

// Chan  Dir  Handshake    Fields
// in_   in   valid/stall  byte, buffer_end
// out_  out  valid/stall  kind, format_code, sample_rate, data_size, sample_byte, status, last
//
// One byte is accepted per cycle while the output queue has room for two results.
// An accepted byte is registered in the input register and parsed from there into the
// output queue; its first result is presented from the queue head.
// Up to two results per byte leave the OUT_DEPTH queue one per cycle while out_stall is low.
// in_stall is high while the input register holds a byte the queue cannot take in full.
// Reset is synchronous on rst_n and returns the parser to the start of a file.

module riff_wave_chunk_parser import rwcp_pkg::*; #(
  parameter int OUT_DEPTH = RWCP_OUT_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_format_code,
  output logic [31:0] out_sample_rate,
  output logic [31:0] out_data_size,
  output logic [7:0]  out_sample_byte,
  output logic [1:0]  out_status,
  output logic        out_last
);

  logic       s1_v_r, s1_v_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic       room, fire, accept;
  push_t      push;
  result_t    head;

  assign fire     = s1_v_r & room;
  assign in_stall = s1_v_r & ~room;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (fire) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_byte;
      s1_end_r  <= in_buffer_end;
    end
  end

  rwcp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .in_byte   (s1_byte_r),
    .buffer_end(s1_end_r),
    .push_o    (push)
  );

  rwcp_outq #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (push),
    .room_o   (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head_o   (head)
  );

  assign out_kind        = head.kind;
  assign out_format_code = head.format_code;
  assign out_sample_rate = head.sample_rate;
  assign out_data_size   = head.data_size;
  assign out_sample_byte = head.sample_byte;
  assign out_status      = head.status;
  assign out_last        = head.last;

endmodule

// ===== rtl/rwcp_parse.sv =====
`timescale 1ns / 1ps

module rwcp_parse import rwcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] in_byte,
  input  logic       buffer_end,
  output push_t      push_o
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hc_r, hc_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] off_r, off_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [15:0] wf_r, wf_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] size_r, size_nxt;
  logic        pcm_r, pcm_nxt;

  logic [4:0]  hc_inc;
  logic [32:0] total;
  logic [33:0] amount;
  logic        active, chunk_done, ended, restart, emit_a, end_v;
  logic [1:0]  a_kind, end_status, fcode;
  result_t     res_a, res_b;

  always_comb begin
    phase_nxt  = phase_r;
    hc_nxt     = hc_r;
    tag_nxt    = tag_r;
    len_nxt    = len_r;
    off_nxt    = off_r;
    rem_nxt    = rem_r;
    wf_nxt     = wf_r;
    ch_nxt     = ch_r;
    depth_nxt  = depth_r;
    rate_nxt   = rate_r;
    size_nxt   = size_r;
    pcm_nxt    = pcm_r;
    hc_inc     = {1'b0, hc_r} + 5'd1;
    total      = {1'b0, len_r} + {32'd0, len_r[0]};
    amount     = '0;
    active     = 1'b1;
    chunk_done = 1'b0;
    ended      = 1'b0;
    restart    = 1'b0;
    emit_a     = 1'b0;
    a_kind     = KIND_SAMPLE;
    end_v      = 1'b0;
    end_status = ST_OK;

    unique case (phase_r)
      PH_FILEHDR: begin
        if (hc_r >= 4'd4 && hc_r < 4'd8) begin
          len_nxt = put_byte(len_r, hc_r[1:0], in_byte);
        end
        if (hc_inc >= 5'd12) begin
          rem_nxt = ((len_nxt + 32'd1) & ~32'd1) - 32'd4;
          len_nxt = '0;
          hc_nxt  = '0;
          if (rem_nxt == '0) begin
            ended = 1'b1;
          end else begin
            phase_nxt = PH_CHUNKHDR;
          end
        end else begin
          hc_nxt = hc_inc[3:0];
        end
      end
      PH_CHUNKHDR: begin
        if (hc_r == '0) begin
          tag_nxt = '0;
          len_nxt = '0;
        end
        if (hc_r < 4'd4) begin
          tag_nxt = {tag_nxt[23:0], in_byte};
        end else begin
          len_nxt = put_byte(len_nxt, hc_r[1:0], in_byte);
        end
        if (hc_inc >= 5'd8) begin
          // Even-rounded body length plus the 8-byte chunk header.
          amount  = {2'b00, len_nxt} + {33'd0, len_nxt[0]} + 34'd8;
          hc_nxt  = '0;
          off_nxt = '0;
          if (amount > {2'b00, rem_r}) begin
            rem_nxt = '0;
          end else begin
            rem_nxt = rem_r - amount[31:0];
          end
          if (tag_nxt == TAG_FMT) begin
            phase_nxt = PH_FMT;
          end else if (tag_nxt == TAG_DATA && wf_r == FMT_PCM) begin
            size_nxt  = len_nxt;
            pcm_nxt   = 1'b1;
            emit_a    = 1'b1;
            a_kind    = KIND_FMT;
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_SKIP;
          end
          if (len_nxt == '0) begin
            chunk_done = 1'b1;
          end
        end else begin
          hc_nxt = hc_inc[3:0];
        end
      end
      PH_FMT, PH_DATA, PH_SKIP: begin
        if (off_r < len_r) begin
          if (phase_r == PH_DATA) begin
            emit_a = 1'b1;
            a_kind = KIND_SAMPLE;
          end else if (phase_r == PH_FMT) begin
            if (off_r == 32'd0) begin
              wf_nxt = {8'd0, in_byte};
            end else if (off_r == 32'd1) begin
              wf_nxt = {in_byte, wf_r[7:0]};
            end else if (wf_r == FMT_PCM) begin
              if (off_r == 32'd2) begin
                ch_nxt[7:0] = in_byte;
              end else if (off_r == 32'd3) begin
                ch_nxt[15:8] = in_byte;
              end else if (off_r >= 32'd4 && off_r < 32'd8) begin
                rate_nxt = put_byte(rate_r, off_r[1:0], in_byte);
              end else if (off_r == 32'd14) begin
                depth_nxt[7:0] = in_byte;
              end else if (off_r == 32'd15) begin
                depth_nxt[15:8] = in_byte;
              end
            end
          end
        end
        // The pad byte after an odd-length body is counted in total.
        if ({1'b0, off_r} + 33'd1 >= total) begin
          chunk_done = 1'b1;
        end else begin
          off_nxt = off_r + 32'd1;
        end
      end
      default: begin
        // Idle: bytes are dropped until the buffer ends.
        active = 1'b0;
        if (buffer_end) begin
          restart = 1'b1;
        end
      end
    endcase

    if (chunk_done) begin
      off_nxt = '0;
      hc_nxt  = '0;
      if (rem_nxt == '0) begin
        ended = 1'b1;
      end else begin
        phase_nxt = PH_CHUNKHDR;
      end
    end

    if (ended) begin
      end_v      = 1'b1;
      end_status = pcm_nxt ? ST_OK : ST_NO_PCM;
      if (buffer_end) begin
        restart = 1'b1;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end else if (buffer_end && active) begin
      end_v      = 1'b1;
      end_status = ST_TRUNC;
      restart    = 1'b1;
    end

    // Reports carry the values as updated by this byte.
    fcode = {ch_nxt != MONO, depth_nxt != DEPTH8};

    res_a.kind        = a_kind;
    res_a.format_code = fcode;
    res_a.sample_rate = rate_nxt;
    res_a.data_size   = size_nxt;
    res_a.sample_byte = (a_kind == KIND_SAMPLE) ? in_byte : 8'd0;
    res_a.status      = ST_OK;
    res_a.last        = ~end_v;

    res_b.kind        = KIND_END;
    res_b.format_code = fcode;
    res_b.sample_rate = rate_nxt;
    res_b.data_size   = size_nxt;
    res_b.sample_byte = 8'd0;
    res_b.status      = end_status;
    res_b.last        = 1'b1;

    if (restart) begin
      phase_nxt = PH_FILEHDR;
      hc_nxt    = '0;
      tag_nxt   = '0;
      len_nxt   = '0;
      off_nxt   = '0;
      rem_nxt   = '0;
      wf_nxt    = '0;
      ch_nxt    = MONO;
      depth_nxt = DEPTH16;
      rate_nxt  = DEFAULT_RATE;
      size_nxt  = '0;
      pcm_nxt   = 1'b0;
    end
  end

  assign push_o.v0 = fire & (emit_a | end_v);
  assign push_o.v1 = fire & emit_a & end_v;
  assign push_o.r0 = emit_a ? res_a : res_b;
  assign push_o.r1 = res_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FILEHDR;
      hc_r    <= '0;
      tag_r   <= '0;
      len_r   <= '0;
      off_r   <= '0;
      rem_r   <= '0;
      wf_r    <= '0;
      ch_r    <= MONO;
      depth_r <= DEPTH16;
      rate_r  <= DEFAULT_RATE;
      size_r  <= '0;
      pcm_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      off_r   <= off_nxt;
      rem_r   <= rem_nxt;
      wf_r    <= wf_nxt;
      ch_r    <= ch_nxt;
      depth_r <= depth_nxt;
      rate_r  <= rate_nxt;
      size_r  <= size_nxt;
      pcm_r   <= pcm_nxt;
    end
  end

endmodule

// ===== rtl/rwcp_outq.sv =====
`timescale 1ns / 1ps

module rwcp_outq import rwcp_pkg::*; #(
  parameter int OUT_DEPTH = RWCP_OUT_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push_i,
  output logic    room_o,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t head_o
);

  localparam int PtrW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int CntW = $clog2(OUT_DEPTH + 1);

  result_t        mem_r [OUT_DEPTH];
  logic [PtrW-1:0] head_r, head_nxt, tail_r, tail_nxt, tail_inc;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            pop;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(OUT_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign pop       = (cnt_r != '0) & ~out_stall;
  assign out_valid = cnt_r != '0;
  assign head_o    = mem_r[head_r];
  // Room for the two results a single item can cause.
  assign room_o    = cnt_r <= CntW'(OUT_DEPTH - 2);
  assign tail_inc  = wrap_inc(tail_r);

  always_comb begin
    head_nxt = pop ? wrap_inc(head_r) : head_r;
    tail_nxt = tail_r;
    if (push_i.v1) begin
      tail_nxt = wrap_inc(tail_inc);
    end else if (push_i.v0) begin
      tail_nxt = tail_inc;
    end
    cnt_nxt = cnt_r + CntW'(push_i.v0) + CntW'(push_i.v1) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.v0) begin
      mem_r[tail_r] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_r[tail_inc] <= push_i.r1;
    end
  end

endmodule

// ===== tb/sv/riff_wave_chunk_parser_tb.sv =====
`timescale 1ns / 1ps

module riff_wave_chunk_parser_tb;
  import rwcp_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [7:0] val;
    logic       buf_end;
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_buffer_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [1:0]  out_format_code;
  logic [31:0] out_sample_rate;
  logic [31:0] out_data_size;
  logic [7:0]  out_sample_byte;
  logic [1:0]  out_status;
  logic        out_last;

  riff_wave_chunk_parser u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_buffer_end  (in_buffer_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_format_code(out_format_code),
    .out_sample_rate(out_sample_rate),
    .out_data_size  (out_data_size),
    .out_sample_byte(out_sample_byte),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  byte_item_t  pending_items[$];
  result_t     expected_results[$];
  logic [7:0]  img[$];

  int errors = 0;
  int items_total = 0;
  int bytes_accepted = 0;
  int files_built = 0;
  int results_seen = 0;
  int n_fmt_reports = 0;
  int n_samples = 0;
  int n_end_ok = 0;
  int n_end_no_pcm = 0;
  int n_end_trunc = 0;
  int cycle_count = 0;

  // Parser state as predicted from the accepted bytes.
  phase_t      ph;
  logic [3:0]  hdr_cnt;
  logic [31:0] tag_acc;
  logic [31:0] chunk_len;
  logic [31:0] chunk_off;
  logic [31:0] file_rem;
  logic [15:0] wfmt;
  logic [15:0] chans;
  logic [15:0] depth;
  logic [31:0] rate;
  logic [31:0] dsize;
  logic        pcm_found;

  task automatic clear_parser_state();
    ph        = PH_FILEHDR;
    hdr_cnt   = 4'd0;
    tag_acc   = 32'd0;
    chunk_len = 32'd0;
    chunk_off = 32'd0;
    file_rem  = 32'd0;
    wfmt      = 16'd0;
    chans     = MONO;
    depth     = DEPTH16;
    rate      = DEFAULT_RATE;
    dsize     = 32'd0;
    pcm_found = 1'b0;
  endtask

  function automatic logic [31:0] with_byte(input logic [31:0] word, input int pos,
                                            input logic [7:0] b);
    logic [31:0] mask;
    mask = 32'hFF << (8 * pos);
    return (word & ~mask) | ({24'h0, b} << (8 * pos));
  endfunction

  function automatic result_t make_result(input logic [1:0] kind, input logic [7:0] sb,
                                          input logic [1:0] st);
    result_t r;
    r.kind        = kind;
    r.format_code = {chans != MONO, depth != DEPTH8};
    r.sample_rate = rate;
    r.data_size   = dsize;
    r.sample_byte = sb;
    r.status      = st;
    r.last        = 1'b0;
    return r;
  endfunction

  // Advances the predicted parser by one byte and queues the results it causes.
  task automatic parse_byte(input logic [7:0] b, input logic endf);
    logic [63:0] total;
    logic [63:0] amount;
    logic        ended;
    logic        chunk_done;
    result_t     outs[2];
    int          n;
    ended      = 1'b0;
    chunk_done = 1'b0;
    n          = 0;
    total      = {32'h0, chunk_len} + chunk_len[0];
    case (ph)
      PH_FILEHDR: begin
        if (hdr_cnt >= 4 && hdr_cnt < 8)
          chunk_len = with_byte(chunk_len, int'(hdr_cnt) - 4, b);
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= 12) begin
          file_rem  = ((chunk_len + 32'd1) & ~32'd1) - 32'd4;
          chunk_len = 32'd0;
          hdr_cnt   = 4'd0;
          if (file_rem == 32'd0)
            ended = 1'b1;
          else
            ph = PH_CHUNKHDR;
        end
      end
      PH_CHUNKHDR: begin
        if (hdr_cnt == 0) begin
          tag_acc   = 32'd0;
          chunk_len = 32'd0;
        end
        if (hdr_cnt < 4)
          tag_acc = {tag_acc[23:0], b};
        else
          chunk_len = with_byte(chunk_len, int'(hdr_cnt) - 4, b);
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= 8) begin
          amount    = (({32'h0, chunk_len} + 64'd1) & ~64'd1) + 64'd8;
          hdr_cnt   = 4'd0;
          chunk_off = 32'd0;
          if (amount > {32'h0, file_rem})
            file_rem = 32'd0;
          else
            file_rem = file_rem - amount[31:0];
          if (tag_acc == TAG_FMT) begin
            ph = PH_FMT;
          end else if (tag_acc == TAG_DATA && wfmt == FMT_PCM) begin
            dsize     = chunk_len;
            pcm_found = 1'b1;
            outs[n]   = make_result(KIND_FMT, 8'h00, ST_OK);
            n++;
            ph = PH_DATA;
          end else begin
            ph = PH_SKIP;
          end
          total = {32'h0, chunk_len} + chunk_len[0];
          if (total == 64'd0)
            chunk_done = 1'b1;
        end
      end
      PH_FMT, PH_DATA, PH_SKIP: begin
        if (chunk_off < chunk_len) begin
          if (ph == PH_DATA) begin
            outs[n] = make_result(KIND_SAMPLE, b, ST_OK);
            n++;
          end else if (ph == PH_FMT) begin
            if (chunk_off == 0)
              wfmt = {8'h00, b};
            else if (chunk_off == 1)
              wfmt = {b, wfmt[7:0]};
            else if (wfmt == FMT_PCM) begin
              if (chunk_off == 2 || chunk_off == 3)
                chans = 16'(with_byte({16'h0, chans}, int'(chunk_off) - 2, b));
              else if (chunk_off >= 4 && chunk_off < 8)
                rate = with_byte(rate, int'(chunk_off) - 4, b);
              else if (chunk_off == 14 || chunk_off == 15)
                depth = 16'(with_byte({16'h0, depth}, int'(chunk_off) - 14, b));
            end
          end
        end
        if ({32'h0, chunk_off} + 64'd1 >= total)
          chunk_done = 1'b1;
        else
          chunk_off = chunk_off + 32'd1;
      end
      default: begin
        // Idle after the end of a file: bytes are dropped up to the buffer end.
        if (endf)
          clear_parser_state();
        return;
      end
    endcase

    if (chunk_done) begin
      chunk_off = 32'd0;
      hdr_cnt   = 4'd0;
      if (file_rem == 32'd0)
        ended = 1'b1;
      else
        ph = PH_CHUNKHDR;
    end

    if (ended) begin
      outs[n] = make_result(KIND_END, 8'h00, pcm_found ? ST_OK : ST_NO_PCM);
      n++;
      if (endf)
        clear_parser_state();
      else
        ph = PH_IDLE;
    end else if (endf) begin
      outs[n] = make_result(KIND_END, 8'h00, ST_TRUNC);
      n++;
      clear_parser_state();
    end

    for (int i = 0; i < n; i++) begin
      if (i == n - 1)
        outs[i].last = 1'b1;
      expected_results.insert(expected_results.size(), outs[i]);
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_result(input result_t got, input result_t want);
    if (got.kind !== want.kind)
      report_mismatch($sformatf("result %0d kind %0d, want %0d",
                                results_seen, got.kind, want.kind));
    if (got.format_code !== want.format_code)
      report_mismatch($sformatf("result %0d format_code %0d, want %0d",
                                results_seen, got.format_code, want.format_code));
    if (got.sample_rate !== want.sample_rate)
      report_mismatch($sformatf("result %0d sample_rate %0d, want %0d",
                                results_seen, got.sample_rate, want.sample_rate));
    if (got.data_size !== want.data_size)
      report_mismatch($sformatf("result %0d data_size %0d, want %0d",
                                results_seen, got.data_size, want.data_size));
    if (got.sample_byte !== want.sample_byte)
      report_mismatch($sformatf("result %0d sample_byte %h, want %h",
                                results_seen, got.sample_byte, want.sample_byte));
    if (got.status !== want.status)
      report_mismatch($sformatf("result %0d status %0d, want %0d",
                                results_seen, got.status, want.status));
    if (got.last !== want.last)
      report_mismatch($sformatf("result %0d last %0d, want %0d",
                                results_seen, got.last, want.last));
  endtask

  task automatic add_byte(input logic [7:0] b);
    img.insert(img.size(), b);
  endtask

  task automatic add_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++)
      add_byte(v[8*i +: 8]);
  endtask

  task automatic add_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--)
      add_byte(t[8*i +: 8]);
  endtask

  // Moves the image into the pending items; the byte at end_at carries buffer_end.
  task automatic queue_image(input int end_at);
    byte_item_t it;
    for (int i = 0; i < img.size(); i++) begin
      it.val     = img[i];
      it.buf_end = (i == end_at);
      pending_items.insert(pending_items.size(), it);
    end
    img.delete();
    files_built++;
  endtask

  // Builds one file image: mostly well-formed fmt and data chunks with random
  // content, some with odd ordering, wrong sizes, truncation or trailing junk.
  task automatic gen_file();
    logic [7:0]  fb[16];
    logic [31:0] len;
    logic [31:0] size;
    int          nch;
    int          sel;
    int          r;
    int          cut;
    bit          well;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 30))
        add_byte(8'($urandom));
      queue_image(img.size() - 1);
    end else begin
      add_tag(32'h5249_4646);
      add_le32(32'd0);
      add_tag(32'h5741_5645);
      well = ($urandom_range(0, 99) < 80);
      nch  = well ? $urandom_range(2, 4) : $urandom_range(1, 4);
      for (int c = 0; c < nch; c++) begin
        if (well)
          sel = (c == 0) ? 0 : (c == 1) ? 1 : $urandom_range(1, 2);
        else
          sel = $urandom_range(0, 2);
        case (sel)
          0: begin
            r   = $urandom_range(0, 99);
            len = (r < 70) ? 32'd16 : (r < 80) ? 32'd18 : 32'($urandom_range(0, 15));
            r   = $urandom_range(0, 99);
            {fb[1], fb[0]} = (r < 80) ? FMT_PCM : (r < 87) ? 16'h0011 :
                             (r < 94) ? 16'h0055 : 16'($urandom);
            r   = $urandom_range(0, 9);
            {fb[3], fb[2]} = (r < 5) ? MONO : (r < 9) ? 16'd2 : 16'($urandom);
            case ($urandom_range(0, 4))
              0:       {fb[7], fb[6], fb[5], fb[4]} = 32'd8000;
              1:       {fb[7], fb[6], fb[5], fb[4]} = DEFAULT_RATE;
              2:       {fb[7], fb[6], fb[5], fb[4]} = 32'd44100;
              3:       {fb[7], fb[6], fb[5], fb[4]} = 32'd48000;
              default: {fb[7], fb[6], fb[5], fb[4]} = $urandom;
            endcase
            for (int i = 8; i < 14; i++)
              fb[i] = 8'($urandom);
            r   = $urandom_range(0, 9);
            {fb[15], fb[14]} = (r < 5) ? DEPTH8 : (r < 9) ? DEPTH16 : 16'($urandom);
            add_tag(TAG_FMT);
            add_le32(len);
            for (int i = 0; i < len; i++)
              add_byte((i < 16) ? fb[i] : 8'($urandom));
            if (len[0])
              add_byte(8'($urandom));
          end
          1: begin
            r = $urandom_range(0, 99);
            add_tag(TAG_DATA);
            if (r < 5) begin
              // Huge length: the file overruns and only the buffer end stops it.
              len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : {1'b1, 31'($urandom)};
              add_le32(len);
              repeat ($urandom_range(0, 6))
                add_byte(8'($urandom));
            end else begin
              len = (r < 15) ? 32'd0 : 32'($urandom_range(1, (r < 85) ? 12 : 40));
              add_le32(len);
              for (int i = 0; i < len; i++)
                add_byte(8'($urandom));
              if (len[0])
                add_byte(8'($urandom));
            end
          end
          default: begin
            r = $urandom_range(0, 3);
            if (r == 0)
              add_tag(TAG_FMT ^ (32'h1 << $urandom_range(0, 31)));
            else if (r == 1)
              add_tag(TAG_DATA ^ (32'h1 << $urandom_range(0, 31)));
            else
              add_tag($urandom);
            len = $urandom_range(0, 10);
            add_le32(len);
            for (int i = 0; i < len; i++)
              add_byte(8'($urandom));
            if (len[0])
              add_byte(8'($urandom));
          end
        endcase
      end
      r    = $urandom_range(0, 99);
      size = img.size() - 8;
      if (r >= 75 && r < 85)
        size = size - $urandom_range(1, 20);
      else if (r >= 85 && r < 93)
        size = size + $urandom_range(1, 9);
      else if (r >= 93)
        size = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF;
      for (int i = 0; i < 4; i++)
        img[4 + i] = size[8*i +: 8];
      r = $urandom_range(0, 99);
      if (r < 55) begin
        queue_image(img.size() - 1);
      end else if (r < 80) begin
        cut = $urandom_range(1, img.size());
        img = img[0:cut-1];
        queue_image(cut - 1);
      end else begin
        repeat ($urandom_range(0, 6))
          add_byte(8'($urandom));
        queue_image(img.size() - 1);
      end
    end
  endtask

  // Sender: bursts of items separated by random gaps.
  int         burst_left = 1;
  int         gap_left = 0;
  int         gap_roll;
  byte_item_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(in_byte, in_buffer_end);
        bytes_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          in_byte       <= next_item.val;
          in_buffer_end <= next_item.buf_end;
          in_valid      <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_roll   = $urandom_range(0, 99);
            gap_left   = (gap_roll < 45) ? 0 : (gap_roll < 85) ? $urandom_range(1, 3) :
                         $urandom_range(4, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result and stalls in changing patterns.
  result_t got_result;
  result_t want_result;
  int      stall_mode = 0;
  int      mode_left = 0;
  int      hold_left = 0;
  int      stall_tick = 0;
  logic    next_stall;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_result = {out_kind, out_format_code, out_sample_rate, out_data_size,
                    out_sample_byte, out_status, out_last};
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d status %0d",
                                  out_kind, out_status));
      end else begin
        want_result = expected_results.pop_front();
        check_result(got_result, want_result);
      end
      results_seen++;
      case (got_result.kind)
        KIND_FMT:    n_fmt_reports++;
        KIND_SAMPLE: n_samples++;
        default: begin
          if (got_result.status == ST_OK)
            n_end_ok++;
          else if (got_result.status == ST_NO_PCM)
            n_end_no_pcm++;
          else
            n_end_trunc++;
        end
      endcase
    end

    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 4);
      mode_left  = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    stall_tick++;
    case (stall_mode)
      1: next_stall = ($urandom_range(0, 9) < 3);
      2: next_stall = ($urandom_range(0, 9) < 7);
      3: next_stall = ((stall_tick % 6) < 2);
      4: begin
        if (hold_left > 0) begin
          hold_left--;
          next_stall = 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
          hold_left  = $urandom_range(2, 10);
          next_stall = 1'b1;
        end else begin
          next_stall = 1'b0;
        end
      end
      default: next_stall = 1'b0;
    endcase
    out_stall <= next_stall;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d bytes accepted",
               cycle_count, bytes_accepted, items_total);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    clear_parser_state();

    // Empty file: a size of 4 leaves nothing after the file header, then an
    // idle byte closes the buffer.
    add_tag(32'h5249_4646);
    add_le32(32'd4);
    add_tag(32'h5741_5645);
    add_byte(8'hFF);
    queue_image(12);

    // Largest sizes everywhere: a maximal data chunk before any fmt chunk is
    // skipped, and the buffer ends on the byte after its header.
    add_tag(32'hFFFF_FFFF);
    add_le32(32'hFFFF_FFFF);
    add_tag(32'h0000_0000);
    add_tag(TAG_DATA);
    add_le32(32'hFFFF_FFFF);
    add_byte(8'h00);
    queue_image(20);

    while (pending_items.size() < RANDOM_ITEMS + 34)
      gen_file();
    items_total = pending_items.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_accepted < items_total)
      @(posedge clk);
    while (expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("ran %0d bytes in %0d file images: %0d format reports, %0d sample bytes",
             bytes_accepted, files_built, n_fmt_reports, n_samples);
    $display("end reports: %0d ok, %0d without PCM data, %0d truncated; %0d mismatches",
             n_end_ok, n_end_no_pcm, n_end_trunc, errors);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
